// File: hw/rtl/bc12_pkg.sv
package bc12_pkg;

    localparam logic [15:0] TICKS_PER_MINUTE = 16'd60000;
    localparam logic [15:0] PULSE_INTERVAL   = 16'd1000;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    localparam logic [3:0] MINUTE_ONES_MAX = 4'd9;
    localparam logic [3:0] MINUTE_TENS_MAX = 4'd5;
    localparam logic [3:0] HOUR_ONES_MAX   = 4'd9;
    localparam logic [3:0] HOUR_ONES_TOP   = 4'd2;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_ACK  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_ALARM_HOUR_TENS   = 3'd0,
        CFG_ALARM_HOUR_ONES   = 3'd1,
        CFG_ALARM_MINUTE_TENS = 3'd2,
        CFG_ALARM_MINUTE_ONES = 3'd3,
        CFG_ALARM_PM          = 3'd4,
        CFG_ALARM_ENABLE      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] load_hour_tens;
        logic [3:0] load_hour_ones;
        logic [3:0] load_minute_tens;
        logic [3:0] load_minute_ones;
        logic       load_pm;
    } t_in_item;

    typedef struct packed {
        logic       hr_tens;
        logic [3:0] hr_ones;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic       is_pm;
        logic       minute_advanced;
        logic       alarm_sounding;
        logic       alarm_pulse;
    } t_out_item;

    typedef struct packed {
        logic       hr_tens;
        logic [3:0] hr_ones;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic       is_pm;
    } t_time;

    typedef struct packed {
        logic minute;
        logic pulse;
        logic sounding;
    } t_tick_stat;

    function automatic t_time clamp_load(input t_in_item item);
        t_time      t;
        logic       ht;
        logic [3:0] ho;
        ht = (item.load_hour_tens != 4'd0);
        ho = item.load_hour_ones;
        if (ht && ho > HOUR_ONES_TOP) ho = HOUR_ONES_TOP;
        if (ho > HOUR_ONES_MAX) ho = HOUR_ONES_MAX;
        t.hr_tens  = ht;
        t.hr_ones  = ho;
        t.min_tens = (item.load_minute_tens > MINUTE_TENS_MAX) ?
                     MINUTE_TENS_MAX[2:0] : item.load_minute_tens[2:0];
        t.min_ones = (item.load_minute_ones > MINUTE_ONES_MAX) ?
                     MINUTE_ONES_MAX : item.load_minute_ones;
        t.is_pm    = item.load_pm;
        return t;
    endfunction

endpackage

// File: hw/rtl/bc12_digit.sv
module bc12_digit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [3:0] i_load_digit,
    input  logic       i_carry,
    input  logic [3:0] i_max,
    output logic [3:0] o_next,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;

    always_comb begin
        o_carry = i_carry && (r_digit >= i_max);
        n_digit = r_digit;
        if (i_load) begin
            n_digit = i_load_digit;
        end else if (i_carry) begin
            n_digit = (r_digit >= i_max) ? 4'd0 : r_digit + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 4'd0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_next = n_digit;

endmodule

// File: hw/rtl/bc12_hour.sv
module bc12_hour import bc12_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_load_tens,
    input  logic [3:0] i_load_ones,
    input  logic       i_load_pm,
    input  logic       i_carry,
    output logic       o_next_tens,
    output logic [3:0] o_next_ones,
    output logic       o_next_pm
);

    logic       r_tens;
    logic [3:0] r_ones;
    logic       r_pm;
    logic       n_tens;
    logic [3:0] n_ones;
    logic       n_pm;

    always_comb begin
        n_tens = r_tens;
        n_ones = r_ones;
        n_pm   = r_pm;
        if (i_load) begin
            n_tens = i_load_tens;
            n_ones = i_load_ones;
            n_pm   = i_load_pm;
        end else if (i_carry) begin
            if (r_tens && r_ones >= HOUR_ONES_TOP) begin
                n_tens = 1'b0;
                n_ones = 4'd1;
            end else if (r_ones >= HOUR_ONES_MAX) begin
                n_tens = 1'b1;
                n_ones = 4'd0;
            end else begin
                n_ones = r_ones + 4'd1;
            end
            if (r_tens && r_ones == 4'd1) begin
                n_pm = ~r_pm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tens <= 1'b1;
            r_ones <= 4'd2;
            r_pm   <= 1'b0;
        end else begin
            r_tens <= n_tens;
            r_ones <= n_ones;
            r_pm   <= n_pm;
        end
    end

    assign o_next_tens = n_tens;
    assign o_next_ones = n_ones;
    assign o_next_pm   = n_pm;

endmodule

// File: hw/rtl/bc12_alarm.sv
module bc12_alarm import bc12_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic       i_tick,
    input  logic       i_ack,
    input  t_time      i_time,
    output logic       o_minute,
    output t_tick_stat o_stat
);

    t_time       r_alarm;
    logic        r_enable;
    logic [15:0] r_ms;
    logic [15:0] r_ivl;
    logic        r_sounding;
    logic [15:0] n_ms;
    logic [15:0] n_ivl;
    logic        n_sounding;
    logic [15:0] ms_inc;
    logic [15:0] ivl_inc;
    logic        minute;
    logic        pulse;
    logic        match;

    assign ms_inc = r_ms + 16'd1;
    assign minute = i_tick && (ms_inc >= TICKS_PER_MINUTE);

    always_comb begin
        ivl_inc = !r_enable ? 16'd0 : ((r_ivl < COUNT_MAX) ? r_ivl + 16'd1 : r_ivl);
        pulse   = i_tick && r_sounding && (ivl_inc >= PULSE_INTERVAL);
        match   = (i_time == r_alarm);
        n_ms       = r_ms;
        n_ivl      = r_ivl;
        n_sounding = r_sounding;
        if (i_tick) begin
            n_ms  = minute ? 16'd0 : ms_inc;
            n_ivl = pulse ? 16'd0 : ivl_inc;
            if (minute && match && r_enable) begin
                n_sounding = 1'b1;
            end
        end else if (i_ack) begin
            n_sounding = 1'b0;
        end
        if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_ALARM_ENABLE) && !i_cfg_data[0]) begin
            n_ivl = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm    <= '0;
            r_enable   <= 1'b0;
            r_ms       <= 16'd0;
            r_ivl      <= 16'd0;
            r_sounding <= 1'b0;
        end else begin
            r_ms       <= n_ms;
            r_ivl      <= n_ivl;
            r_sounding <= n_sounding;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ALARM_HOUR_TENS:   r_alarm.hr_tens  <= i_cfg_data[0];
                    CFG_ALARM_HOUR_ONES:   r_alarm.hr_ones  <= i_cfg_data;
                    CFG_ALARM_MINUTE_TENS: r_alarm.min_tens <= i_cfg_data[2:0];
                    CFG_ALARM_MINUTE_ONES: r_alarm.min_ones <= i_cfg_data;
                    CFG_ALARM_PM:          r_alarm.is_pm    <= i_cfg_data[0];
                    CFG_ALARM_ENABLE:      r_enable         <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_minute        = minute;
    assign o_stat.minute   = minute;
    assign o_stat.pulse    = pulse;
    assign o_stat.sounding = n_sounding;

endmodule

// File: hw/rtl/bcd_12h_clock_with_alarm.sv
// BCD 12-hour clock with alarm.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one event per
// transaction: a millisecond tick, a time load, or an alarm acknowledge.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns one result
// per event: the time after the event, the minute flag, the sounding flag
// and the buzzer pulse flag.
// The result sits in the output register the cycle after the event is taken.
// Throughput is one event per cycle while the receiver does not stall; the minute
// digits, hour cell and tick counters all update in the same cycle.
// When the receiver stalls, the result holds in the output register and
// o_in_stall rises while that register is full, so no event is lost.
// The config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes the alarm time
// and enable; write it only while no event is in flight.
// Synchronous reset sets the time to 12:00 AM, clears the counters, the
// sounding flag and the alarm registers, and empties the output register.
module bcd_12h_clock_with_alarm import bc12_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data
);

    logic       accept;
    logic       do_tick;
    logic       do_load;
    logic       do_ack;
    t_time      load_time;
    t_time      next_time;
    t_tick_stat stat;
    logic       minute_done;
    logic [3:0] mo_next;
    logic [3:0] mt_next;
    logic       mo_carry;
    logic       mt_carry;
    logic       r_out_valid;
    t_out_item  r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign do_tick    = accept && (t_mode'(i_in_data.mode) == MODE_TICK);
    assign do_load    = accept && (t_mode'(i_in_data.mode) == MODE_LOAD);
    assign do_ack     = accept && (t_mode'(i_in_data.mode) == MODE_ACK);
    assign load_time  = clamp_load(i_in_data);

    bc12_digit u_minute_ones (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (do_load),
        .i_load_digit (load_time.min_ones),
        .i_carry      (minute_done),
        .i_max        (MINUTE_ONES_MAX),
        .o_next       (mo_next),
        .o_carry      (mo_carry)
    );

    bc12_digit u_minute_tens (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (do_load),
        .i_load_digit ({1'b0, load_time.min_tens}),
        .i_carry      (mo_carry),
        .i_max        (MINUTE_TENS_MAX),
        .o_next       (mt_next),
        .o_carry      (mt_carry)
    );

    bc12_hour u_hour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (do_load),
        .i_load_tens (load_time.hr_tens),
        .i_load_ones (load_time.hr_ones),
        .i_load_pm   (load_time.is_pm),
        .i_carry     (mt_carry),
        .o_next_tens (next_time.hr_tens),
        .o_next_ones (next_time.hr_ones),
        .o_next_pm   (next_time.is_pm)
    );

    assign next_time.min_ones = mo_next;
    assign next_time.min_tens = mt_next[2:0];

    bc12_alarm u_alarm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (do_tick),
        .i_ack      (do_ack),
        .i_time     (next_time),
        .o_minute   (minute_done),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.hr_tens         <= next_time.hr_tens;
            r_out.hr_ones         <= next_time.hr_ones;
            r_out.min_tens        <= next_time.min_tens;
            r_out.min_ones        <= next_time.min_ones;
            r_out.is_pm           <= next_time.is_pm;
            r_out.minute_advanced <= stat.minute;
            r_out.alarm_sounding  <= stat.sounding;
            r_out.alarm_pulse     <= stat.pulse;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pulse_needs_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.alarm_pulse |-> r_out.alarm_sounding)
        else $error("pulse without sounding flag");

    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.min_ones <= MINUTE_ONES_MAX &&
                        r_out.min_tens <= MINUTE_TENS_MAX[2:0] &&
                        r_out.hr_ones <= HOUR_ONES_MAX)
        else $error("time digit out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted event left no result");

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bc12_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int unsigned IDLE_PCT      = 14;
    localparam int unsigned QUIET_FROM    = 600;
    localparam int unsigned QUIET_TO      = 1_000;
    localparam int unsigned HOLD_AT       = 30;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned NUM_BATCHES   = 8;
    localparam int unsigned BATCH_LEN     = 110;
    localparam int unsigned MAX_REPORTS   = 200;
    localparam int unsigned RUN_LIMIT     = 20_000;

    typedef struct {
        t_in_item  ev;
        bit        pinned;
        t_out_item want;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data  = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we   = 1'b0;
    logic [2:0] i_cfg_idx  = '0;
    logic [3:0] i_cfg_data = '0;

    bcd_12h_clock_with_alarm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock model state
    logic [15:0] clk_ms;
    logic [15:0] buzz_count;
    t_time       now;
    logic        ringing;
    t_time       alarm_at;
    logic        alarm_on;

    t_out_item   expected_results[$];
    t_dir_row    script[$];

    int unsigned cyc = 0;
    int unsigned fails = 0;
    int unsigned sent = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    int unsigned hold_left = 0;
    bit          held = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    initial begin
        wait (cyc >= RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit quiet_now();
        return cyc >= QUIET_FROM && cyc < QUIET_TO;
    endfunction

    function automatic t_time mk_time(input int unsigned ht, input int unsigned ho,
                                      input int unsigned mt, input int unsigned mo,
                                      input int unsigned pm);
        t_time t;
        t.hr_tens  = ht[0];
        t.hr_ones  = ho[3:0];
        t.min_tens = mt[2:0];
        t.min_ones = mo[3:0];
        t.is_pm    = pm[0];
        return t;
    endfunction

    function automatic t_in_item mk_ev(input logic [1:0] m, input int unsigned ht,
                                       input int unsigned ho, input int unsigned mt,
                                       input int unsigned mo, input int unsigned pm);
        t_in_item ev;
        ev.mode             = m;
        ev.load_hour_tens   = ht[3:0];
        ev.load_hour_ones   = ho[3:0];
        ev.load_minute_tens = mt[3:0];
        ev.load_minute_ones = mo[3:0];
        ev.load_pm          = pm[0];
        return ev;
    endfunction

    function automatic t_in_item mk_load(input t_time t);
        t_in_item ev;
        ev.mode             = MODE_LOAD;
        ev.load_hour_tens   = {3'b0, t.hr_tens};
        ev.load_hour_ones   = t.hr_ones;
        ev.load_minute_tens = {1'b0, t.min_tens};
        ev.load_minute_ones = t.min_ones;
        ev.load_pm          = t.is_pm;
        return ev;
    endfunction

    function automatic t_out_item mk_out(input t_time t);
        return {t, 3'b000};
    endfunction

    function automatic t_time rand_time();
        t_time t;
        t.hr_tens  = 1'($urandom_range(1));
        t.hr_ones  = t.hr_tens ? 4'($urandom_range(2)) : 4'($urandom_range(9));
        t.min_tens = 3'($urandom_range(5));
        t.min_ones = 4'($urandom_range(9));
        t.is_pm    = 1'($urandom_range(1));
        return t;
    endfunction

    function automatic t_in_item rand_event();
        t_in_item    ev;
        int unsigned pick;
        ev   = t_in_item'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            ev.mode = MODE_TICK;
        end else if (pick < 50) begin
            ev = mk_load(rand_time());
        end else if (pick < 65) begin
            ev.mode = MODE_LOAD;
        end else if (pick < 85) begin
            ev.mode = MODE_ACK;
        end else begin
            ev.mode = MODE_UNUSED;
        end
        return ev;
    endfunction

    function automatic t_time step_minute(input t_time t);
        t_time n;
        n = t;
        if (n.min_ones >= 4'd9) begin
            n.min_ones = 4'd0;
            if (n.min_tens >= 3'd5) begin
                n.min_tens = 3'd0;
                if (n.hr_tens && n.hr_ones >= 4'd2) begin
                    n.hr_tens = 1'b0;
                    n.hr_ones = 4'd1;
                end else if (n.hr_ones >= 4'd9) begin
                    n.hr_tens = 1'b1;
                    n.hr_ones = 4'd0;
                end else begin
                    n.hr_ones = n.hr_ones + 4'd1;
                end
            end else begin
                n.min_tens = n.min_tens + 3'd1;
            end
        end else begin
            n.min_ones = n.min_ones + 4'd1;
        end
        if (n.hr_tens && n.hr_ones == 4'd2 && n.min_tens == 3'd0 &&
            n.min_ones == 4'd0) begin
            n.is_pm = ~n.is_pm;
        end
        return n;
    endfunction

    function automatic t_time clamp_entry(input t_in_item ev);
        t_time t;
        t.hr_tens = (ev.load_hour_tens != 4'd0);
        t.hr_ones = ev.load_hour_ones;
        if (t.hr_tens && t.hr_ones > 4'd2) t.hr_ones = 4'd2;
        if (t.hr_ones > 4'd9) t.hr_ones = 4'd9;
        t.min_tens = (ev.load_minute_tens > 4'd5) ? 3'd5 : ev.load_minute_tens[2:0];
        t.min_ones = (ev.load_minute_ones > 4'd9) ? 4'd9 : ev.load_minute_ones;
        t.is_pm    = ev.load_pm;
        return t;
    endfunction

    task automatic apply_event(input t_in_item ev, output t_out_item res);
        logic advanced;
        logic pulse;
        advanced = 1'b0;
        pulse    = 1'b0;
        case (ev.mode)
            MODE_TICK: begin
                clk_ms = clk_ms + 16'd1;
                if (!alarm_on) begin
                    buzz_count = '0;
                end else if (buzz_count != COUNT_MAX) begin
                    buzz_count = buzz_count + 16'd1;
                end
                if (ringing && buzz_count >= PULSE_INTERVAL) begin
                    pulse      = 1'b1;
                    buzz_count = '0;
                end
                if (clk_ms >= TICKS_PER_MINUTE) begin
                    clk_ms   = '0;
                    now      = step_minute(now);
                    advanced = 1'b1;
                    if (alarm_on && now == alarm_at) ringing = 1'b1;
                end
            end
            MODE_LOAD: now = clamp_entry(ev);
            MODE_ACK:  ringing = 1'b0;
            default: ;
        endcase
        res = {now, advanced, ringing, pulse};
    endtask

    task automatic send_event(input t_in_item ev, input bit pinned, input t_out_item want);
        t_out_item res;
        while (!quiet_now() && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) begin
            stall_cycles++;
            @(posedge i_clk);
        end
        apply_event(ev, res);
        if (pinned) res = want;
        expected_results.push_back(res);
        sent++;
    endtask

    task automatic send_random();
        send_event(rand_event(), 1'b0, '0);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ALARM_HOUR_TENS:   alarm_at.hr_tens  = val[0];
            CFG_ALARM_HOUR_ONES:   alarm_at.hr_ones  = val;
            CFG_ALARM_MINUTE_TENS: alarm_at.min_tens = val[2:0];
            CFG_ALARM_MINUTE_ONES: alarm_at.min_ones = val;
            CFG_ALARM_PM:          alarm_at.is_pm    = val[0];
            CFG_ALARM_ENABLE: begin
                alarm_on = val[0];
                if (!val[0]) buzz_count = '0;
            end
            default: ;
        endcase
    endtask

    task automatic set_alarm(input t_time a, input logic en);
        write_reg(CFG_ALARM_HOUR_TENS,   {3'b0, a.hr_tens});
        write_reg(CFG_ALARM_HOUR_ONES,   a.hr_ones);
        write_reg(CFG_ALARM_MINUTE_TENS, {1'b0, a.min_tens});
        write_reg(CFG_ALARM_MINUTE_ONES, a.min_ones);
        write_reg(CFG_ALARM_PM,          {3'b0, a.is_pm});
        write_reg(CFG_ALARM_ENABLE,      {3'b0, en});
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    task automatic take_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            fails++;
            $error("result %h arrived with no transaction outstanding", got);
            return;
        end
        want = expected_results.pop_front();
        check_field("hr_tens",  32'(want.hr_tens),  32'(got.hr_tens));
        check_field("hr_ones",  32'(want.hr_ones),  32'(got.hr_ones));
        check_field("min_tens", 32'(want.min_tens), 32'(got.min_tens));
        check_field("min_ones", 32'(want.min_ones), 32'(got.min_ones));
        check_field("is_pm",    32'(want.is_pm),    32'(got.is_pm));
        check_field("minute_advanced", 32'(want.minute_advanced),
                    32'(got.minute_advanced));
        check_field("alarm_sounding", 32'(want.alarm_sounding),
                    32'(got.alarm_sounding));
        check_field("alarm_pulse", 32'(want.alarm_pulse), 32'(got.alarm_pulse));
    endtask

    task automatic add_row(input t_in_item ev, input bit pinned, input t_out_item want);
        t_dir_row row;
        row.ev     = ev;
        row.pinned = pinned;
        row.want   = want;
        script.push_back(row);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) take_result(o_out_data);
            if (!held && results_seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_now() && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        t_time al;
        logic  en;

        clk_ms     = '0;
        buzz_count = '0;
        now        = mk_time(1, 2, 0, 0, 0);
        ringing    = 1'b0;
        alarm_at   = '0;
        alarm_on   = 1'b0;

        add_row(mk_ev(MODE_TICK, 0, 0, 0, 0, 0), 1'b1, mk_out(mk_time(1, 2, 0, 0, 0)));
        add_row(mk_ev(MODE_LOAD, 15, 15, 15, 15, 1), 1'b1, mk_out(mk_time(1, 2, 5, 9, 1)));
        add_row(mk_ev(MODE_TICK, 15, 15, 15, 15, 1), 1'b0, '0);
        add_row(mk_ev(MODE_LOAD, 0, 15, 15, 15, 0), 1'b1, mk_out(mk_time(0, 9, 5, 9, 0)));
        add_row(mk_ev(MODE_LOAD, 0, 0, 0, 0, 0), 1'b1, mk_out(mk_time(0, 0, 0, 0, 0)));
        add_row(mk_ev(MODE_UNUSED, 15, 15, 15, 15, 1), 1'b1, mk_out(mk_time(0, 0, 0, 0, 0)));
        add_row(mk_ev(MODE_ACK, 15, 15, 15, 15, 1), 1'b1, mk_out(mk_time(0, 0, 0, 0, 0)));
        add_row(mk_ev(MODE_LOAD, 1, 2, 0, 0, 0), 1'b1, mk_out(mk_time(1, 2, 0, 0, 0)));
        add_row(mk_ev(MODE_LOAD, 1, 3, 0, 0, 1), 1'b1, mk_out(mk_time(1, 2, 0, 0, 1)));
        add_row(mk_ev(MODE_LOAD, 1, 0, 9, 9, 0), 1'b1, mk_out(mk_time(1, 0, 5, 9, 0)));
        add_row(mk_ev(MODE_LOAD, 1, 1, 5, 9, 1), 1'b1, mk_out(mk_time(1, 1, 5, 9, 1)));
        add_row(mk_ev(MODE_LOAD, 2, 9, 6, 10, 0), 1'b1, mk_out(mk_time(1, 2, 5, 9, 0)));
        add_row(mk_ev(MODE_LOAD, 0, 10, 0, 0, 1), 1'b1, mk_out(mk_time(0, 9, 0, 0, 1)));
        add_row(mk_ev(MODE_LOAD, 8, 4, 5, 9, 0), 1'b1, mk_out(mk_time(1, 2, 5, 9, 0)));
        add_row(mk_ev(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(MODE_ACK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(MODE_UNUSED, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_ev(MODE_LOAD, 0, 1, 2, 3, 1), 1'b0, '0);
        add_row(mk_ev(MODE_TICK, 9, 5, 7, 3, 0), 1'b0, '0);
        add_row(mk_ev(MODE_LOAD, 1, 1, 4, 7, 0), 1'b0, '0);
        add_row(mk_ev(MODE_TICK, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(mk_ev(MODE_ACK, 6, 10, 12, 3, 1), 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            send_event(script[k].ev, script[k].pinned, script[k].want);
        end

        for (int unsigned b = 0; b < NUM_BATCHES; b++) begin
            settle();
            al = rand_time();
            en = 1'($urandom_range(1));
            set_alarm(al, en);
            repeat (BATCH_LEN) send_random();
        end

        settle();
        $display("Run summary: %0d transactions, directed clamp and mode rows, then random",
                 sent);
        $display("ticks, loads, acks and unused modes over %0d alarm settings; %0d stall cycles",
                 NUM_BATCHES, stall_cycles);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bc12_pkg.sv
hw/rtl/bc12_digit.sv
hw/rtl/bc12_hour.sv
hw/rtl/bc12_alarm.sv
hw/rtl/bcd_12h_clock_with_alarm.sv
tb/tb.sv
